[design/nnps_pkg.sv]
// nnps_pkg: shared types and constants for the nearest neighbor preview scaler
// payload structs, config register map, controller/datapath command and status
// no dependencies
package nnps_pkg;

	localparam int CFG_W   = 13;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int PIX_W   = 8;
	localparam int SUM3_W  = 10;
	localparam int MEAN_W  = 18;
	localparam int FRAC_W  = 8;
	localparam int DIM_W   = 13;

	localparam logic [SUM3_W-1:0] SUM3_MAX = 10'd765;

	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH   = 13'd1;
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT  = 13'd1;
	localparam logic [CFG_W-1:0] RST_PREVIEW_LIMIT = 13'd256;

	typedef enum logic [1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_LIMIT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEL_DIMS = 2'd0,
		SEL_COL  = 2'd1,
		SEL_ROW  = 2'd2,
		SEL_MEAN = 2'd3
	} div_sel_t;

	typedef struct packed {
		logic [CFG_W-1:0] image_width;
		logic [CFG_W-1:0] image_height;
		logic [CFG_W-1:0] preview_limit;
	} cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] in_red;
		logic [PIX_W-1:0] in_green;
		logic [PIX_W-1:0] in_blue;
		logic [PIX_W-1:0] in_alpha;
	} src_pix_t;

	typedef struct packed {
		logic              pixel_valid;
		logic [PIX_W-1:0]  out_red;
		logic [PIX_W-1:0]  out_green;
		logic [PIX_W-1:0]  out_blue;
		logic [PIX_W-1:0]  out_alpha;
		logic              stats_valid;
		logic [SUM3_W-1:0] min_rgb_sum;
		logic [SUM3_W-1:0] max_rgb_sum;
		logic [MEAN_W-1:0] mean_rgb_sum_q8;
		logic [DIM_W-1:0]  preview_width;
		logic [DIM_W-1:0]  preview_height;
	} res_t;

	typedef struct packed {
		logic     load;
		logic     update;
		logic     emit_pixel;
		logic     emit_final;
		logic     div_start;
		div_sel_t div_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic frame_start;
		logic last_pixel;
		logic sampled;
		logic count_zero;
		logic div_busy;
		logic div_done;
	} dp_sts_t;

endpackage

[design/nnps_regs.sv]
// nnps_regs: apb-style configuration registers of the preview scaler
// depends on nnps_pkg
module nnps_regs import nnps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg,
	output logic               cfg_wr
);

	cfg_t cfg_q;
	logic wr_en;

	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;
	assign cfg_wr = wr_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= RST_IMAGE_WIDTH;
			cfg_q.image_height  <= RST_IMAGE_HEIGHT;
			cfg_q.preview_limit <= RST_PREVIEW_LIMIT;
		end else if (wr_en) begin
			unique case (paddr[PADDR_W-1:2])
				REG_WIDTH: begin
					cfg_q.image_width <= pwdata[CFG_W-1:0];
				end
				REG_HEIGHT: begin
					cfg_q.image_height <= pwdata[CFG_W-1:0];
				end
				REG_LIMIT: begin
					cfg_q.preview_limit <= pwdata[CFG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[PADDR_W-1:2])
			REG_WIDTH: begin
				prdata = PDATA_W'(cfg_q.image_width);
			end
			REG_HEIGHT: begin
				prdata = PDATA_W'(cfg_q.image_height);
			end
			REG_LIMIT: begin
				prdata = PDATA_W'(cfg_q.preview_limit);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

[design/nnps_div.sv]
// nnps_div: restoring divider, one quotient bit per cycle
// quotient must fit QUO_W bits; no package dependency
module nnps_div #(
	parameter int NUM_W = 43,
	parameter int DEN_W = 25,
	parameter int QUO_W = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [QUO_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(QUO_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> QUO_W);
			quo_q <= num[QUO_W-1:0];
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

[design/nnps_datapath.sv]
// nnps_datapath: position trackers, sample steps, statistics and result register
// depends on nnps_pkg and nnps_div
module nnps_datapath import nnps_pkg::*; #(
	parameter int MAX_SIDE = 4096
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  src_pix_t src_data,
	input  dp_cmd_t  cmd,
	output dp_sts_t  sts,
	output res_t     res_data
);

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int POS_W  = SIDE_W + 1;
	localparam int CNT_W  = 2 * $clog2(MAX_SIDE) + 1;
	localparam int SUM_W  = CNT_W + SUM3_W;
	localparam int NUM_W  = SUM_W + FRAC_W;
	localparam int DEN_W  = CNT_W;
	localparam int QUO_W  = (SIDE_W > MEAN_W) ? SIDE_W : MEAN_W;
	localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

	function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return SIDE_W'(1);
		end else if (32'(v) > 32'(MAX_SIDE)) begin
			return SIDE_MAX;
		end else begin
			return SIDE_W'(v);
		end
	endfunction

	src_pix_t          pix_q;
	logic [SIDE_W-1:0] col_q;
	logic [SIDE_W-1:0] row_q;
	logic [POS_W-1:0]  nsc_q;
	logic [SIDE_W-1:0] crem_q;
	logic [POS_W-1:0]  nsr_q;
	logic [SIDE_W-1:0] rrem_q;
	logic [SIDE_W-1:0] pw_q;
	logic [SIDE_W-1:0] ph_q;
	logic [SIDE_W-1:0] cstep_q;
	logic [SIDE_W-1:0] cmod_q;
	logic [SIDE_W-1:0] rstep_q;
	logic [SIDE_W-1:0] rmod_q;
	logic [SUM3_W-1:0] min_q;
	logic [SUM3_W-1:0] max_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [MEAN_W-1:0] mean_q;
	logic              sampled_q;
	div_sel_t          sel_q;
	res_t              out_q;

	logic [SIDE_W-1:0]   w_eff;
	logic [SIDE_W-1:0]   h_eff;
	logic [CFG_W-1:0]    lim;
	logic                w_ge_h;
	logic [SIDE_W-1:0]   long_side;
	logic [SIDE_W-1:0]   short_side;
	logic [SIDE_W-1:0]   chosen;
	logic [2*SIDE_W-1:0] dims_prod;
	logic [SIDE_W-1:0]   q_side;

	logic [SIDE_W:0]   col_next1;
	logic [SIDE_W:0]   row_next1;
	logic              last_col;
	logic              last_row;
	logic              row_hit;
	logic              sampled;
	logic [SUM3_W-1:0] sum3;
	logic [SIDE_W:0]   crem_sum;
	logic              cwrap;
	logic [SIDE_W-1:0] crem_adv;
	logic [POS_W-1:0]  nsc_adv;
	logic [SIDE_W:0]   rrem_sum;
	logic              rwrap;
	logic [SIDE_W-1:0] rrem_adv;
	logic [POS_W-1:0]  nsr_adv;

	logic             div_busy;
	logic             div_done;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic [QUO_W-1:0] div_quo;
	logic [DEN_W-1:0] div_rem;
	logic             dims_done;

	res_t res_pix;
	res_t res_final;

	assign w_eff      = eff_side(cfg.image_width);
	assign h_eff      = eff_side(cfg.image_height);
	assign lim        = (cfg.preview_limit == '0) ? CFG_W'(1) : cfg.preview_limit;
	assign w_ge_h     = w_eff >= h_eff;
	assign long_side  = w_ge_h ? w_eff : h_eff;
	assign short_side = w_ge_h ? h_eff : w_eff;
	assign chosen     = (32'(lim) < 32'(long_side)) ? SIDE_W'(lim) : long_side;
	assign dims_prod  = (2*SIDE_W)'(short_side) * (2*SIDE_W)'(chosen);
	assign q_side     = (div_quo == '0) ? SIDE_W'(1) : SIDE_W'(div_quo);

	assign col_next1 = {1'b0, col_q} + (SIDE_W+1)'(1);
	assign row_next1 = {1'b0, row_q} + (SIDE_W+1)'(1);
	assign last_col  = col_next1 >= {1'b0, w_eff};
	assign last_row  = row_next1 >= {1'b0, h_eff};
	assign row_hit   = {1'b0, row_q} == nsr_q;
	assign sampled   = row_hit && ({1'b0, col_q} == nsc_q);
	assign sum3      = SUM3_W'(pix_q.in_red) + SUM3_W'(pix_q.in_green)
		+ SUM3_W'(pix_q.in_blue);

	// column and row sample steps with carried remainder
	assign crem_sum = {1'b0, crem_q} + {1'b0, cmod_q};
	assign cwrap    = crem_sum >= {1'b0, pw_q};
	assign crem_adv = cwrap ? SIDE_W'(crem_sum - {1'b0, pw_q}) : SIDE_W'(crem_sum);
	assign nsc_adv  = nsc_q + POS_W'(cstep_q) + POS_W'(cwrap);
	assign rrem_sum = {1'b0, rrem_q} + {1'b0, rmod_q};
	assign rwrap    = rrem_sum >= {1'b0, ph_q};
	assign rrem_adv = rwrap ? SIDE_W'(rrem_sum - {1'b0, ph_q}) : SIDE_W'(rrem_sum);
	assign nsr_adv  = nsr_q + POS_W'(rstep_q) + POS_W'(rwrap);

	always_comb begin
		div_num = NUM_W'(w_eff);
		div_den = DEN_W'(pw_q);
		unique case (cmd.div_sel)
			SEL_DIMS: begin
				div_num = NUM_W'(dims_prod);
				div_den = DEN_W'(long_side);
			end
			SEL_COL: begin
				div_num = NUM_W'(w_eff);
				div_den = DEN_W'(pw_q);
			end
			SEL_ROW: begin
				div_num = NUM_W'(h_eff);
				div_den = DEN_W'(ph_q);
			end
			SEL_MEAN: begin
				div_num = {sum_q, FRAC_W'(0)};
				div_den = cnt_q;
			end
			default: begin
			end
		endcase
	end

	nnps_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W),
		.QUO_W(QUO_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	assign dims_done = div_done && (sel_q == SEL_DIMS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			nsc_q  <= '0;
			crem_q <= '0;
			nsr_q  <= '0;
			rrem_q <= '0;
			pw_q   <= SIDE_W'(1);
			ph_q   <= SIDE_W'(1);
			min_q  <= SUM3_MAX;
			max_q  <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else if (dims_done) begin
			// frame start: latch preview size and clear trackers
			if (w_ge_h) begin
				pw_q <= chosen;
				ph_q <= q_side;
			end else begin
				pw_q <= q_side;
				ph_q <= chosen;
			end
			nsc_q  <= '0;
			crem_q <= '0;
			nsr_q  <= '0;
			rrem_q <= '0;
			min_q  <= SUM3_MAX;
			max_q  <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
		end else if (cmd.update) begin
			if (sampled) begin
				if (sum3 < min_q) begin
					min_q <= sum3;
				end
				if (sum3 > max_q) begin
					max_q <= sum3;
				end
				sum_q  <= sum_q + SUM_W'(sum3);
				cnt_q  <= cnt_q + CNT_W'(1);
				nsc_q  <= nsc_adv;
				crem_q <= crem_adv;
			end
			if (last_col) begin
				col_q  <= '0;
				nsc_q  <= '0;
				crem_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					nsr_q  <= '0;
					rrem_q <= '0;
				end else begin
					row_q <= SIDE_W'(row_next1);
					if (row_hit) begin
						nsr_q  <= nsr_adv;
						rrem_q <= rrem_adv;
					end
				end
			end else begin
				col_q <= SIDE_W'(col_next1);
			end
		end
	end

	always_comb begin
		res_pix                = '0;
		res_pix.pixel_valid    = sampled;
		res_pix.preview_width  = DIM_W'(pw_q);
		res_pix.preview_height = DIM_W'(ph_q);
		if (sampled) begin
			res_pix.out_red   = pix_q.in_red;
			res_pix.out_green = pix_q.in_green;
			res_pix.out_blue  = pix_q.in_blue;
			res_pix.out_alpha = pix_q.in_alpha;
		end
		res_final                = '0;
		res_final.pixel_valid    = sampled_q;
		res_final.stats_valid    = 1'b1;
		res_final.preview_width  = DIM_W'(pw_q);
		res_final.preview_height = DIM_W'(ph_q);
		if (sampled_q) begin
			res_final.out_red   = pix_q.in_red;
			res_final.out_green = pix_q.in_green;
			res_final.out_blue  = pix_q.in_blue;
			res_final.out_alpha = pix_q.in_alpha;
		end
		if (cnt_q != '0) begin
			res_final.min_rgb_sum     = min_q;
			res_final.max_rgb_sum     = max_q;
			res_final.mean_rgb_sum_q8 = mean_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pix_q <= src_data;
		end
		if (cmd.update) begin
			sampled_q <= sampled;
		end
		if (cmd.div_start) begin
			sel_q <= cmd.div_sel;
		end
		if (div_done) begin
			unique case (sel_q)
				SEL_COL: begin
					cstep_q <= SIDE_W'(div_quo);
					cmod_q  <= SIDE_W'(div_rem);
				end
				SEL_ROW: begin
					rstep_q <= SIDE_W'(div_quo);
					rmod_q  <= SIDE_W'(div_rem);
				end
				SEL_MEAN: begin
					mean_q <= MEAN_W'(div_quo);
				end
				default: begin
				end
			endcase
		end
		if (cmd.emit_pixel) begin
			out_q <= res_pix;
		end else if (cmd.emit_final) begin
			out_q <= res_final;
		end
	end

	assign sts.frame_start = (col_q == '0) && (row_q == '0);
	assign sts.last_pixel  = last_col && last_row;
	assign sts.sampled     = sampled;
	assign sts.count_zero  = cnt_q == '0;
	assign sts.div_busy    = div_busy;
	assign sts.div_done    = div_done;
	assign res_data        = out_q;

endmodule

[design/nnps_ctrl.sv]
// nnps_ctrl: sequencer for pixel transfers, frame-edge divides and result hand-off
// depends on nnps_pkg
module nnps_ctrl import nnps_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    src_valid,
	output logic    src_ready,
	output logic    res_valid,
	input  logic    res_ready,
	input  logic    cfg_wr,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_PROC   = 9'b000000010,
		ST_DIMS   = 9'b000000100,
		ST_COL_GO = 9'b000001000,
		ST_COL    = 9'b000010000,
		ST_ROW    = 9'b000100000,
		ST_STATS  = 9'b001000000,
		ST_MEAN   = 9'b010000000,
		ST_FINAL  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   dirty_q;
	logic   prepped_q;
	logic   slot_free;
	logic   prep_needed;
	logic   prep_done;

	assign slot_free   = !out_valid_q || res_ready;
	assign prep_needed = dirty_q || (sts.frame_start && !prepped_q);

	always_comb begin
		cmd         = '0;
		cmd.div_sel = SEL_COL;
		state_d     = state_q;
		src_ready   = 1'b0;
		prep_done   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				src_ready = 1'b1;
				if (src_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PROC;
				end
			end
			ST_PROC: begin
				if (prep_needed) begin
					cmd.div_start = 1'b1;
					if (sts.frame_start && !prepped_q) begin
						cmd.div_sel = SEL_DIMS;
						state_d     = ST_DIMS;
					end else begin
						cmd.div_sel = SEL_COL;
						state_d     = ST_COL;
					end
				end else if (sts.last_pixel) begin
					cmd.update = 1'b1;
					state_d    = ST_STATS;
				end else if (sts.sampled && !slot_free) begin
					state_d = ST_PROC;
				end else begin
					cmd.update     = 1'b1;
					cmd.emit_pixel = sts.sampled;
					src_ready      = 1'b1;
					if (src_valid) begin
						cmd.load = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DIMS: begin
				if (sts.div_done) begin
					state_d = ST_COL_GO;
				end
			end
			ST_COL_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = SEL_COL;
				state_d       = ST_COL;
			end
			ST_COL: begin
				if (sts.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = SEL_ROW;
					state_d       = ST_ROW;
				end
			end
			ST_ROW: begin
				if (sts.div_done) begin
					prep_done = 1'b1;
					state_d   = ST_PROC;
				end
			end
			ST_STATS: begin
				if (sts.count_zero) begin
					state_d = ST_FINAL;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = SEL_MEAN;
					state_d       = ST_MEAN;
				end
			end
			ST_MEAN: begin
				if (sts.div_done) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (slot_free) begin
					cmd.emit_final = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			dirty_q     <= 1'b0;
			prepped_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit_pixel || cmd.emit_final) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			// a register write invalidates the sample steps
			if (cfg_wr) begin
				dirty_q <= 1'b1;
			end else if (prep_done) begin
				dirty_q <= 1'b0;
			end
			if (prep_done) begin
				prepped_q <= 1'b1;
			end else if (cmd.update) begin
				prepped_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;

`ifndef SYNTHESIS
	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_pixel || cmd.emit_final) |-> (!out_valid_q || res_ready))
		else $error("result written while output register still holds a transfer");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.div_busy)
		else $error("divider started while busy");

	a_load_proc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == ST_PROC))
		else $error("accepted pixel not processed next cycle");

	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_DIMS || state_q == ST_COL
			|| state_q == ST_ROW || state_q == ST_MEAN))
		else $error("divider finished outside a wait state");
`endif

endmodule

[design/nearest_neighbor_preview_scaler_unit.sv]
// nearest_neighbor_preview_scaler_unit: top level of the preview scaler
// ordinary pixels: one per cycle while the result slot is free; result registered as processed
// first pixel of a frame: waits for three divides on the shared one-bit-per-cycle divider
// (preview size, column and row steps)
// last pixel: waits for the mean divide if any pixel was sampled; after a register write the
// next pixel waits two divides; async reset clears control state, no clearing pass
module nearest_neighbor_preview_scaler_unit import nnps_pkg::*; #(
	parameter int MAX_SIDE = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               src_valid,
	output logic               src_ready,
	input  src_pix_t           src_data,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res_data
);

	cfg_t    cfg;
	logic    cfg_wr;
	dp_cmd_t cmd;
	dp_sts_t sts;

	nnps_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg),
		.cfg_wr (cfg_wr)
	);

	nnps_datapath #(
		.MAX_SIDE(MAX_SIDE)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.src_data(src_data),
		.cmd     (cmd),
		.sts     (sts),
		.res_data(res_data)
	);

	nnps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.cfg_wr   (cfg_wr),
		.sts      (sts),
		.cmd      (cmd)
	);

endmodule
